// ===== sv/tocq_pkg.sv =====
// Package for the tick ordered command queue: widths, status codes, FSM states
// and the controller/datapath command and status structs. No dependencies.
package tocq_pkg;

    localparam int TICK_W = 32;
    localparam int PRIO_W = 2;
    localparam int SEQ_W  = 16;
    localparam int KIND_W = 3;
    localparam int CHAIN_W = 8;
    localparam int PAY_W  = 32;
    localparam int CFG_W  = 9;
    localparam int STAT_W = 3;
    localparam int PEND_W = 5;
    localparam int MAX_RESULTS = 16;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NONE_DUE = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_CHAIN = 3'd2;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd3;
    localparam logic [STAT_W-1:0] ST_STALE    = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic                 action;
        logic [TICK_W-1:0]    target_tick;
        logic [PRIO_W-1:0]    source_priority;
        logic [SEQ_W-1:0]     sequence_req;
        logic [KIND_W-1:0]    command_kind;
        logic [CHAIN_W-1:0]   chain;
        logic [PAY_W-1:0]     payload_tag;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [TICK_W-1:0]    out_tick;
        logic [PRIO_W-1:0]    out_priority;
        logic [SEQ_W-1:0]     out_sequence;
        logic [KIND_W-1:0]    out_kind;
        logic [CHAIN_W-1:0]   out_chain;
        logic [PAY_W-1:0]     out_payload;
        logic                 last;
        logic [PEND_W-1:0]    pending_after;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SELECT,
        S_EMIT,
        S_WAIT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture the request, reset scan counter
        logic scan_step;  // examine one slot
        logic sel_start;  // begin a selection pass
        logic sel_step;   // examine one slot for selection
        logic emit;       // move result into output register
        logic finish;     // commit push or stale drop after scan
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_take;
        logic bad_chain;
        logic scan_done;
        logic sel_done;
        logic found;      // a due entry was selected in the pass
        logic stale;
        logic dup;
        logic out_busy;   // output register still holds an untaken result
        logic count_max;  // MAX_RESULTS already released
    } dp_stat_t;

endpackage

// ===== sv/tocq_if.sv =====
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; payload types come from tocq_pkg.
interface tocq_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tick_ordered_command_queue.sv =====
// Tick ordered command queue, top level: controller plus datapath.
// A push scans every slot, one step per slot; a bad chain resolves at once.
// A take scans for stale entries and, if none, runs a selection pass per
// released request and a final pass that releases nothing.
// One request is worked at a time. rst_n clears all valid bits, the result
// valid flag and sets valid_chain_count to 4; no clearing pass is needed.
module tick_ordered_command_queue
    import tocq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    tocq_if.sink             req_ch,
    tocq_if.source           rsp_ch
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    // The controller sequences scan, selection and result emission.
    tocq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the entries and compares one slot per cycle.
    tocq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req       (req_ch.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (rsp_ch.valid),
        .out_ready (rsp_ch.ready),
        .out_data  (rsp_ch.data)
    );

    assign req_ch.ready = in_ready;

endmodule

// ===== sv/tocq_ctrl.sv =====
// Controller state machine for the command queue.
// Depends on tocq_pkg; drives tocq_dp through dp_cmd_t.
module tocq_ctrl
    import tocq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // Bad chain resolves at once; otherwise walk every slot.
                if (!stat.is_take && stat.bad_chain)
                    state_next = S_WAIT;
                else if (stat.scan_done)
                    state_next = (stat.is_take && !stat.stale) ? S_SELECT : S_WAIT;
            end
            S_SELECT:
            begin
                if (stat.sel_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Result is buffered one behind, so selection of the next one
                // overlaps the wait for the consumer.
                if (!stat.out_busy)
                    state_next = (stat.found && !stat.count_max) ? S_SELECT : S_WAIT;
            end
            S_WAIT:
            begin
                if (!stat.out_busy)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if ((!stat.is_take && stat.bad_chain) || stat.scan_done)
                begin
                    cmd.finish = 1'b1;
                    cmd.sel_start = stat.is_take && !stat.stale;
                end
            end
            S_SELECT:
            begin
                cmd.sel_step = 1'b1;
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel_start = stat.found && !stat.count_max;
                end
            end
            S_WAIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sv/tocq_dp.sv =====
// Datapath of the command queue: entry store, scan and selection registers,
// result register. Depends on tocq_pkg; controlled by tocq_ctrl.
module tocq_dp
    import tocq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  req_t             req,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    output logic             out_valid,
    input  logic             out_ready,
    output rsp_t             out_data
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RC_W  = $clog2(MAX_RESULTS + 1);

    // Entry store: key and body per slot, one valid bit per slot.
    logic [TICK_W-1:0]  tick_mem    [QUEUE_DEPTH];
    logic [PRIO_W-1:0]  prio_mem    [QUEUE_DEPTH];
    logic [SEQ_W-1:0]   seq_mem     [QUEUE_DEPTH];
    logic [KIND_W-1:0]  kind_mem    [QUEUE_DEPTH];
    logic [CHAIN_W-1:0] chain_mem   [QUEUE_DEPTH];
    logic [PAY_W-1:0]   pay_mem     [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;

    logic [CFG_W-1:0] vcc_reg;
    req_t             req_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             dup_reg, dup_next;
    logic             stale_reg, stale_next;
    logic             free_ok_reg, free_ok_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic [QUEUE_DEPTH-1:0] drop_reg, drop_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic [RC_W-1:0]  rel_cnt_reg, rel_cnt_next;
    logic [CNT_W-1:0] live_reg, live_next;
    // Number of entries due at the take tick, and the count left afterwards.
    logic [CNT_W-1:0] due_cnt_reg, due_cnt_next;
    logic [PEND_W-1:0] pend_fin_reg, pend_fin_next;
    // Pending result held until the lookahead selection tells if it is last.
    logic             hold_reg, hold_next;
    rsp_t             hold_data_reg, hold_data_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;

    logic [IDX_W-1:0] cur;
    logic             scan_done;
    logic             hit_dup, hit_stale, due, better;

    assign cur = idx_reg[IDX_W-1:0];
    assign scan_done = (idx_reg == CNT_W'(QUEUE_DEPTH - 1));
    assign hit_dup = valid_reg[cur] && tick_mem[cur] == req_reg.target_tick &&
                     prio_mem[cur] == req_reg.source_priority &&
                     seq_mem[cur] == req_reg.sequence_req;
    assign hit_stale = valid_reg[cur] && tick_mem[cur] < req_reg.target_tick;
    assign due = valid_reg[cur] && tick_mem[cur] == req_reg.target_tick;
    // Order among due entries: priority, sequence, kind, then slot (scan order).
    assign better = !found_reg ||
        {prio_mem[cur], seq_mem[cur], kind_mem[cur]} <
        {prio_mem[best_reg], seq_mem[best_reg], kind_mem[best_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcc_reg       <= CFG_W'(4);
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            hold_reg      <= 1'b0;
            live_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                vcc_reg <= cfg_data;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            hold_reg      <= hold_next;
            live_reg      <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        idx_reg       <= idx_next;
        dup_reg       <= dup_next;
        stale_reg     <= stale_next;
        free_ok_reg   <= free_ok_next;
        free_reg      <= free_next;
        drop_reg      <= drop_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        rel_cnt_reg   <= rel_cnt_next;
        due_cnt_reg   <= due_cnt_next;
        pend_fin_reg  <= pend_fin_next;
        hold_data_reg <= hold_data_next;
        out_reg       <= out_next;
        if (cmd.finish && !req_reg.action && !dup_next && free_ok_next &&
            !(req_reg.chain >= vcc_reg))
        begin
            tick_mem[free_next]  <= req_reg.target_tick;
            prio_mem[free_next]  <= req_reg.source_priority;
            seq_mem[free_next]   <= req_reg.sequence_req;
            kind_mem[free_next]  <= req_reg.command_kind;
            chain_mem[free_next] <= req_reg.chain;
            pay_mem[free_next]   <= req_reg.payload_tag;
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        dup_next       = dup_reg;
        stale_next     = stale_reg;
        free_ok_next   = free_ok_reg;
        free_next      = free_reg;
        drop_next      = drop_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        rel_cnt_next   = rel_cnt_reg;
        due_cnt_next   = due_cnt_reg;
        pend_fin_next  = pend_fin_reg;
        valid_next     = valid_reg;
        live_next      = live_reg;
        hold_next      = hold_reg;
        hold_data_next = hold_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        if (cmd.load)
        begin
            idx_next     = '0;
            dup_next     = 1'b0;
            stale_next   = 1'b0;
            free_ok_next = 1'b0;
            drop_next    = '0;
            rel_cnt_next = '0;
            due_cnt_next = '0;
            hold_next    = 1'b0;
        end

        if (cmd.scan_step)
        begin
            if (req_reg.action)
            begin
                if (hit_stale)
                begin
                    stale_next = 1'b1;
                    drop_next[cur] = 1'b1;
                end
                if (due)
                    due_cnt_next = due_cnt_reg + CNT_W'(1);
            end
            else if (valid_reg[cur])
            begin
                if (hit_dup)
                    dup_next = 1'b1;
            end
            else if (!free_ok_reg)
            begin
                free_ok_next = 1'b1;
                free_next    = cur;
            end
            idx_next = idx_reg + CNT_W'(1);
        end

        if (cmd.finish)
        begin
            out_next = '0;
            out_next.last = 1'b1;
            if (!req_reg.action)
            begin
                if (req_reg.chain >= vcc_reg)
                    out_next.status = ST_BAD_CHAIN;
                else if (dup_next)
                    out_next.status = ST_DUP;
                else if (!free_ok_next)
                    out_next.status = ST_FULL;
                else
                begin
                    out_next.status = ST_OK;
                    valid_next[free_next] = 1'b1;
                    live_next = live_reg + CNT_W'(1);
                end
                out_next.pending_after = PEND_W'(live_next);
                out_valid_next = 1'b1;
            end
            else if (stale_next)
            begin
                valid_next = valid_reg & ~drop_next;
                live_next  = CNT_W'($countones(valid_next));
                out_next.status = ST_STALE;
                out_next.pending_after = PEND_W'(live_next);
                out_valid_next = 1'b1;
            end
            else
            begin
                // Every release of this take reports the count left at its end.
                pend_fin_next = (int'(due_cnt_next) > MAX_RESULTS) ?
                    PEND_W'(int'(live_reg) - MAX_RESULTS) :
                    PEND_W'(live_reg - due_cnt_next);
            end
        end

        if (cmd.sel_start)
        begin
            idx_next   = '0;
            found_next = 1'b0;
        end

        if (cmd.sel_step)
        begin
            if (due && better)
            begin
                found_next = 1'b1;
                best_next  = cur;
            end
            idx_next = idx_reg + CNT_W'(1);
        end

        if (cmd.emit)
        begin
            // The held result goes out; its last flag is known now.
            if (hold_reg)
            begin
                out_next = hold_data_reg;
                out_next.last = !(found_reg && rel_cnt_reg != RC_W'(MAX_RESULTS));
                out_valid_next = 1'b1;
            end
            else if (!found_reg)
            begin
                out_next = '0;
                out_next.status = ST_NONE_DUE;
                out_next.last = 1'b1;
                out_next.pending_after = PEND_W'(live_reg);
                out_valid_next = 1'b1;
            end
            if (found_reg && rel_cnt_reg != RC_W'(MAX_RESULTS))
            begin
                hold_next = 1'b1;
                hold_data_next.status = ST_OK;
                hold_data_next.out_tick = tick_mem[best_reg];
                hold_data_next.out_priority = prio_mem[best_reg];
                hold_data_next.out_sequence = seq_mem[best_reg];
                hold_data_next.out_kind = kind_mem[best_reg];
                hold_data_next.out_chain = chain_mem[best_reg];
                hold_data_next.out_payload = pay_mem[best_reg];
                hold_data_next.last = 1'b0;
                hold_data_next.pending_after = '0;
                valid_next[best_reg] = 1'b0;
                live_next = live_reg - CNT_W'(1);
                rel_cnt_next = rel_cnt_reg + RC_W'(1);
            end
            else
            begin
                hold_next = 1'b0;
            end
            // pending_after is the count after the whole take.
            if (hold_reg)
                out_next.pending_after = pend_fin_reg;
        end
    end

    always_comb
    begin
        stat.is_take   = req_reg.action;
        stat.bad_chain = req_reg.chain >= vcc_reg;
        stat.scan_done = scan_done;
        stat.sel_done  = scan_done;
        stat.found     = found_reg;
        stat.stale     = stale_next;
        stat.dup       = dup_reg;
        stat.out_busy  = out_valid_reg && !out_ready;
        stat.count_max = (rel_cnt_reg == RC_W'(MAX_RESULTS));
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/tocq_checker.sv =====
// Port-level checker for the command queue, bound to the top level.
// Depends on tocq_pkg.
module tocq_checker
    import tocq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input rsp_t out_data
);

    // A result held back by the consumer does not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A new request is never taken in the cycle after one is taken.
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted back to back");

    // Results with a status other than ST_OK carry a zero tick and are last.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.out_tick == '0 && out_data.last)
        else $error("single result not clean");

    // Status codes stay in range.
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= ST_FULL)
        else $error("bad status");

endmodule

bind tick_ordered_command_queue tocq_checker u_tocq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req_ch.valid),
    .in_ready  (req_ch.ready),
    .out_valid (rsp_ch.valid),
    .out_ready (rsp_ch.ready),
    .out_data  (rsp_ch.data)
);
